// ----- hdl/exchange_field_accumulator_macros.svh -----
// Assertion macros shared by the exchange field accumulator checkers.
`ifndef EXCHANGE_FIELD_ACCUMULATOR_MACROS_SVH
`define EXCHANGE_FIELD_ACCUMULATOR_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define EFA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("efa checker: property violated");

// Clocked assertion that is also checked while reset is asserted.
`define EFA_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("efa checker: property violated around reset");

`endif

// ----- hdl/efa_pkg.sv -----
// Shared constants, codes and stage types of the exchange field accumulator.
`timescale 1ns / 1ps

package efa_pkg;

	localparam int NUM_TYPES = 256;
	localparam int SLOTS     = 9;
	localparam int TYPE_W    = 8;
	localparam int SLOT_W    = 4;
	localparam int COEFF_W   = 24;
	localparam int SPIN_W    = 16;
	localparam int FIELD_W   = 48;
	localparam int MODE_W    = 2;
	localparam int TYPE_AW   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int PROD_W    = COEFF_W + SPIN_W;
	localparam int TERM_W    = PROD_W + 2;

	localparam logic CMD_TERM  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [MODE_W-1:0] MODE_ISO    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VEC    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TENSOR = 2'd2;

	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef logic signed [SPIN_W-1:0]  spin_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [FIELD_W-1:0] field_t;

	localparam field_t FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam field_t FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

	// Term after the coefficient read: table words plus the captured spin.
	typedef struct packed {
		logic                            valid;
		logic                            last;
		logic                            type_ok;
		logic [MODE_W-1:0]               mode;
		logic [SPIN_W-1:0]               spin_x;
		logic [SPIN_W-1:0]               spin_y;
		logic [SPIN_W-1:0]               spin_z;
		logic [SLOTS-1:0][COEFF_W-1:0]   coef;
	} stage1_t;

	// Term after the row sums: one signed contribution per component.
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [TERM_W-1:0] term_x;
		logic [TERM_W-1:0] term_y;
		logic [TERM_W-1:0] term_z;
	} stage3_t;

endpackage

// ----- hdl/efa_if.sv -----
// Item and result channel interfaces of the exchange field accumulator.
`timescale 1ns / 1ps

interface efa_item_if;
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic [efa_pkg::TYPE_W-1:0]          type_index;
	logic [efa_pkg::SLOT_W-1:0]          coeff_slot;
	logic signed [efa_pkg::COEFF_W-1:0]  coeff_value;
	logic signed [efa_pkg::SPIN_W-1:0]   spin_x;
	logic signed [efa_pkg::SPIN_W-1:0]   spin_y;
	logic signed [efa_pkg::SPIN_W-1:0]   spin_z;
	logic                                last;

	modport source (
		output valid, cmd, type_index, coeff_slot, coeff_value, spin_x, spin_y, spin_z, last,
		input  ready
	);
	modport sink (
		input  valid, cmd, type_index, coeff_slot, coeff_value, spin_x, spin_y, spin_z, last,
		output ready
	);
endinterface

interface efa_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [efa_pkg::FIELD_W-1:0]  field_x;
	logic signed [efa_pkg::FIELD_W-1:0]  field_y;
	logic signed [efa_pkg::FIELD_W-1:0]  field_z;
	logic                                saturated;

	modport source (output valid, field_x, field_y, field_z, saturated, input ready);
	modport sink (input valid, field_x, field_y, field_z, saturated, output ready);
endinterface

// ----- hdl/efa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module efa_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/efa_coeff_store.sv -----
// Coefficient table in nine slot banks, and the first pipeline stage.
`timescale 1ns / 1ps

module efa_coeff_store (
	input  logic                        clk,
	input  logic                        arst_n,
	efa_item_if.sink                    item,
	input  logic [efa_pkg::MODE_W-1:0]  mode,
	input  logic                        down_ready,
	output efa_pkg::stage1_t            s1
);
	import efa_pkg::*;

	logic               load_s1;
	logic               accept;
	logic               is_term;
	logic               type_ok;
	logic [TYPE_AW-1:0] addr;
	logic [SLOTS-1:0]   bank_we;
	logic [COEFF_W-1:0] rdata [SLOTS];

	logic               valid_s1;
	logic               last_s1;
	logic               type_ok_s1;
	logic [MODE_W-1:0]  mode_s1;
	spin_t              spin_x_s1;
	spin_t              spin_y_s1;
	spin_t              spin_z_s1;

	assign load_s1    = !valid_s1 || down_ready;
	assign item.ready = load_s1;
	assign accept     = item.valid && load_s1;
	assign is_term    = (item.cmd == CMD_TERM);
	assign type_ok    = (32'(item.type_index) < NUM_TYPES);
	assign addr       = TYPE_AW'(item.type_index);

	// Each slot has its own bank so that a term reads all nine words at once.
	// A write and the next term's read both happen at accept edges, so a term
	// right behind a write already sees the new word.
	for (genvar k = 0; k < SLOTS; k++) begin : g_bank
		assign bank_we[k] = accept && !is_term && type_ok &&
			(item.coeff_slot == SLOT_W'(k));

		efa_ram #(
			.WIDTH(COEFF_W),
			.DEPTH(NUM_TYPES)
		) u_bank (
			.clk  (clk),
			.we   (bank_we[k]),
			.waddr(addr),
			.wdata(item.coeff_value),
			.re   (accept && is_term),
			.raddr(addr),
			.rdata(rdata[k])
		);

		assign s1.coef[k] = rdata[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= accept && is_term;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_term) begin
			last_s1    <= item.last;
			type_ok_s1 <= type_ok;
			mode_s1    <= mode;
			spin_x_s1  <= item.spin_x;
			spin_y_s1  <= item.spin_y;
			spin_z_s1  <= item.spin_z;
		end
	end

	assign s1.valid   = valid_s1;
	assign s1.last    = last_s1;
	assign s1.type_ok = type_ok_s1;
	assign s1.mode    = mode_s1;
	assign s1.spin_x  = spin_x_s1;
	assign s1.spin_y  = spin_y_s1;
	assign s1.spin_z  = spin_z_s1;

endmodule

// ----- hdl/efa_product.sv -----
// Coefficient selection by mode, the nine products and the three row sums.
`timescale 1ns / 1ps

module efa_product (
	input  logic             clk,
	input  logic             arst_n,
	input  efa_pkg::stage1_t s1,
	input  logic             down_ready,
	output logic             up_ready,
	output efa_pkg::stage3_t s3
);
	import efa_pkg::*;

	logic   load_s2;
	logic   load_s3;
	coeff_t op [SLOTS];
	spin_t  spin [3];

	logic   valid_s2;
	logic   last_s2;
	prod_t  prod_s2 [SLOTS];

	logic   valid_s3;
	logic   last_s3;
	term_t  term_s3 [3];

	assign load_s3  = !valid_s3 || down_ready;
	assign load_s2  = !valid_s2 || load_s3;
	assign up_ready = load_s2;

	assign spin[0] = $signed(s1.spin_x);
	assign spin[1] = $signed(s1.spin_y);
	assign spin[2] = $signed(s1.spin_z);

	// The operands form a 3x3 matrix applied to the spin; the scalar and
	// vector forms only fill its diagonal. An unknown type adds nothing.
	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			op[k] = '0;
		end
		if (s1.type_ok) begin
			case (s1.mode)
				MODE_ISO: begin
					op[0] = $signed(s1.coef[0]);
					op[4] = $signed(s1.coef[0]);
					op[8] = $signed(s1.coef[0]);
				end
				MODE_VEC: begin
					op[0] = $signed(s1.coef[0]);
					op[4] = $signed(s1.coef[1]);
					op[8] = $signed(s1.coef[2]);
				end
				MODE_TENSOR: begin
					for (int k = 0; k < SLOTS; k++) begin
						op[k] = $signed(s1.coef[k]);
					end
				end
				default: begin
					for (int k = 0; k < SLOTS; k++) begin
						op[k] = $signed(s1.coef[k]);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (load_s2) begin
				valid_s2 <= s1.valid;
			end
			if (load_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			last_s2 <= s1.last;
			for (int k = 0; k < SLOTS; k++) begin
				prod_s2[k] <= op[k] * spin[k % 3];
			end
		end
		if (load_s3) begin
			last_s3 <= last_s2;
			for (int r = 0; r < 3; r++) begin
				term_s3[r] <= term_t'(prod_s2[3*r]) + term_t'(prod_s2[3*r+1]) +
					term_t'(prod_s2[3*r+2]);
			end
		end
	end

	assign s3.valid  = valid_s3;
	assign s3.last   = last_s3;
	assign s3.term_x = term_s3[0];
	assign s3.term_y = term_s3[1];
	assign s3.term_z = term_s3[2];

endmodule

// ----- hdl/efa_accum.sv -----
// Saturating field accumulator and the result register.
`timescale 1ns / 1ps

module efa_accum (
	input  logic             clk,
	input  logic             arst_n,
	input  efa_pkg::stage3_t s3,
	output logic             up_ready,
	efa_result_if.source     result
);
	import efa_pkg::*;

	logic                  fire;
	logic                  any_ovf;
	term_t                 term [3];
	logic signed [FIELD_W:0] diff [3];
	logic [2:0]            ovf;
	field_t                sat [3];

	field_t                sum_q [3];
	logic                  clip_q;
	logic                  out_valid_q;
	field_t                field_q [3];
	logic                  saturated_q;

	// Only a last term needs the result register; other terms go on into the
	// sums while a finished result waits.
	assign up_ready = !s3.last || !out_valid_q || result.ready;
	assign fire     = s3.valid && up_ready;

	assign term[0] = $signed(s3.term_x);
	assign term[1] = $signed(s3.term_y);
	assign term[2] = $signed(s3.term_z);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			diff[r] = (FIELD_W+1)'(sum_q[r]) - (FIELD_W+1)'(term[r]);
			ovf[r]  = diff[r][FIELD_W] != diff[r][FIELD_W-1];
			if (ovf[r]) begin
				sat[r] = diff[r][FIELD_W] ? FIELD_MIN : FIELD_MAX;
			end else begin
				sat[r] = diff[r][FIELD_W-1:0];
			end
		end
	end

	assign any_ovf = |ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				sum_q[r] <= '0;
			end
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				if (s3.last) begin
					for (int r = 0; r < 3; r++) begin
						sum_q[r] <= '0;
					end
					clip_q      <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					for (int r = 0; r < 3; r++) begin
						sum_q[r] <= sat[r];
					end
					clip_q <= clip_q || any_ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && s3.last) begin
			for (int r = 0; r < 3; r++) begin
				field_q[r] <= sat[r];
			end
			saturated_q <= clip_q || any_ovf;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.field_x   = field_q[0];
	assign result.field_y   = field_q[1];
	assign result.field_z   = field_q[2];
	assign result.saturated = saturated_q;

endmodule

// ----- hdl/exchange_field_accumulator.sv -----
// Top level: accumulates the exchange field of one atom over its neighbour terms.
// Throughput: one item per cycle, coefficient writes and neighbour terms alike, unless a blocked result backs it up.
// The result of a last term passes through the pipeline registers of table read,
// product, row sum and saturating accumulate.
// Reset clears the mode, the sums, the clip flag and all stage valids at once;
// the coefficient table is not cleared and reads are defined only once written.
`timescale 1ns / 1ps

module exchange_field_accumulator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [efa_pkg::MODE_W-1:0]  cfg_wdata,
	efa_item_if.sink                    item,
	efa_result_if.source                result
);
	import efa_pkg::*;

	logic [MODE_W-1:0] mode_q;
	stage1_t           s1;
	stage3_t           s3;
	logic              prod_ready;
	logic              acc_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ISO;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	efa_coeff_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.mode      (mode_q),
		.down_ready(prod_ready),
		.s1        (s1)
	);

	efa_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.down_ready(acc_ready),
		.up_ready  (prod_ready),
		.s3        (s3)
	);

	efa_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.s3      (s3),
		.up_ready(acc_ready),
		.result  (result)
	);

endmodule

// ----- hdl/efa_checker.sv -----
// Port-level assertions for the exchange field accumulator, bound to the top level.
`timescale 1ns / 1ps
`include "exchange_field_accumulator_macros.svh"

module efa_checker (
	input  logic          clk,
	input  logic          arst_n,
	efa_item_if.sink      item,
	efa_result_if.source  result
);
	import efa_pkg::*;

	logic [3*FIELD_W:0] result_bits;
	logic               last_in;

	assign result_bits = {result.field_x, result.field_y, result.field_z, result.saturated};
	assign last_in     = item.valid && item.ready && item.cmd == CMD_TERM && item.last;

	// A waiting result beat keeps its value until it is taken.
	`EFA_ASSERT(a_result_hold, clk, arst_n, result.valid && !result.ready |=> result.valid && $stable(result_bits))

	// Input is held off only when the pipeline backs up behind a blocked result.
	`EFA_ASSERT(a_ready_only_blocked, clk, arst_n, !item.ready |-> result.valid && !result.ready)

	// With the result side open while it passes the stages, a last term comes out as a valid result.
	`EFA_ASSERT(a_last_latency, clk, arst_n, last_in ##1 result.ready [*3] |=> result.valid)

	// No result is offered while reset is held.
	`EFA_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !result.valid)

endmodule

bind exchange_field_accumulator efa_checker u_efa_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.item  (item),
	.result(result)
);

// ----- verif/efa_field_check.sv -----
// Field checker: predicts the exchange field from the item beats and compares each result beat.
`timescale 1ns / 1ps

module efa_field_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [efa_pkg::MODE_W-1:0] cfg_wdata,
	efa_item_if                        item,
	efa_result_if                      result,
	output int                         fail_count,
	output int                         pending
);
	import efa_pkg::*;

	localparam longint SUM_TOP    = longint'(FIELD_MAX);
	localparam longint SUM_BOTTOM = longint'(FIELD_MIN);

	typedef struct packed {
		field_t x;
		field_t y;
		field_t z;
		logic   saturated;
	} field_rec_t;

	coeff_t            coef_mem [NUM_TYPES*SLOTS];
	logic [MODE_W-1:0] mode_q;
	longint            sum_x, sum_y, sum_z;
	logic              clip_seen;
	field_rec_t        field_q [$];
	field_rec_t        want;
	longint            j [SLOTS];
	longint            sx, sy, sz, tx, ty, tz;
	int                base;
	logic              type_ok;

	function automatic longint clip_sub(input longint acc, input longint term,
			inout logic clipped);
		longint r;
		r = acc - term;
		if (r > SUM_TOP) begin
			clipped = 1'b1;
			r = SUM_TOP;
		end else if (r < SUM_BOTTOM) begin
			clipped = 1'b1;
			r = SUM_BOTTOM;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input field_t exp_v,
			input field_t got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_ISO;
			sum_x = 0;
			sum_y = 0;
			sum_z = 0;
			clip_seen = 1'b0;
			field_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Retire the oldest expectation before this edge's item can add one.
			if (result.valid && result.ready) begin
				if (field_q.size() == 0) begin
					$display("%0t: result beat expected none, got field_x %0d",
						$time, result.field_x);
					fail_count++;
				end else begin
					want = field_q.pop_front();
					check_field("field_x", want.x, result.field_x);
					check_field("field_y", want.y, result.field_y);
					check_field("field_z", want.z, result.field_z);
					check_field("saturated", field_t'(want.saturated),
						field_t'(result.saturated));
				end
			end

			if (item.valid && item.ready) begin
				type_ok = int'(item.type_index) < NUM_TYPES;
				base = int'(item.type_index) * SLOTS;
				if (item.cmd == CMD_WRITE) begin
					if (type_ok && int'(item.coeff_slot) < SLOTS)
						coef_mem[base + int'(item.coeff_slot)] = item.coeff_value;
				end else begin
					for (int k = 0; k < SLOTS; k++)
						j[k] = type_ok ? longint'(coef_mem[base + k]) : 0;
					sx = longint'(item.spin_x);
					sy = longint'(item.spin_y);
					sz = longint'(item.spin_z);
					case (mode_q)
						MODE_ISO: begin
							tx = j[0] * sx;
							ty = j[0] * sy;
							tz = j[0] * sz;
						end
						MODE_VEC: begin
							tx = j[0] * sx;
							ty = j[1] * sy;
							tz = j[2] * sz;
						end
						default: begin
							// Tensor mode; the undefined mode code behaves the same.
							tx = j[0] * sx + j[1] * sy + j[2] * sz;
							ty = j[3] * sx + j[4] * sy + j[5] * sz;
							tz = j[6] * sx + j[7] * sy + j[8] * sz;
						end
					endcase
					sum_x = clip_sub(sum_x, tx, clip_seen);
					sum_y = clip_sub(sum_y, ty, clip_seen);
					sum_z = clip_sub(sum_z, tz, clip_seen);
					if (item.last) begin
						want.x = field_t'(sum_x);
						want.y = field_t'(sum_y);
						want.z = field_t'(sum_z);
						want.saturated = clip_seen;
						field_q = {field_q, want};
						sum_x = 0;
						sum_y = 0;
						sum_z = 0;
						clip_seen = 1'b0;
					end
				end
			end

			if (cfg_we)
				mode_q = cfg_wdata;
			pending = field_q.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top: drives coefficient loads and neighbour terms into the exchange field accumulator.
`timescale 1ns / 1ps

module tb_top;
	import efa_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 8;
	localparam int PHASE_BEATS  = 150;
	localparam int CLIP_TERMS   = 200;

	localparam coeff_t COEFF_TOP    = {1'b0, {(COEFF_W-1){1'b1}}};
	localparam coeff_t COEFF_BOTTOM = {1'b1, {(COEFF_W-1){1'b0}}};
	localparam spin_t  SPIN_TOP     = {1'b0, {(SPIN_W-1){1'b1}}};
	localparam spin_t  SPIN_BOTTOM  = {1'b1, {(SPIN_W-1){1'b0}}};
	localparam coeff_t EDGE_COEFFS [SLOTS] = '{COEFF_TOP, COEFF_BOTTOM, 24'sd0, 24'sd1,
		-24'sd1, 24'sd65536, -24'sd65536, 24'sd12345, -24'sd777};

	typedef struct packed {
		logic                cmd;
		logic [TYPE_W-1:0]   type_index;
		logic [SLOT_W-1:0]   coeff_slot;
		coeff_t              coeff_value;
		spin_t               spin_x;
		spin_t               spin_y;
		spin_t               spin_z;
		logic                last;
	} beat_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_wdata;
	int                fail_count;
	int                pending;
	int                src_idle_pct;
	int                sink_stall_pct;
	int                beats_sent;
	int                cycle_count = 0;
	bit                loaded [NUM_TYPES][SLOTS];
	bit                set_complete [NUM_TYPES];
	int                usable_types [$];

	efa_item_if   item_ch ();
	efa_result_if result_ch ();

	exchange_field_accumulator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	efa_field_check field_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item       (item_ch),
		.result     (result_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	always @(negedge clk) result_ch.ready = ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic spin_t rand_spin();
		case ($urandom_range(9))
			0: return SPIN_TOP;
			1: return SPIN_BOTTOM;
			default: return spin_t'($urandom);
		endcase
	endfunction

	function automatic coeff_t rand_coeff();
		case ($urandom_range(9))
			0: return COEFF_TOP;
			1: return COEFF_BOTTOM;
			default: return coeff_t'($urandom);
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] phase_mode(input int p);
		case (p)
			0, 6: return MODE_ISO;
			1, 4: return MODE_VEC;
			2, 5: return MODE_TENSOR;
			default: return MODE_UNDEF;
		endcase
	endfunction

	// Neighbour term; the coefficient fields are don't-care and get random content.
	function automatic beat_t term_beat(input int t, input logic last_flag);
		beat_t b;
		b.cmd = CMD_TERM;
		b.type_index = TYPE_W'(t);
		b.coeff_slot = SLOT_W'($urandom);
		b.coeff_value = rand_coeff();
		b.spin_x = rand_spin();
		b.spin_y = rand_spin();
		b.spin_z = rand_spin();
		b.last = last_flag;
		return b;
	endfunction

	// Coefficient write; spin and last are ignored by the block and get random content.
	function automatic beat_t write_beat(input int t, input int s, input coeff_t v);
		beat_t b;
		b.cmd = CMD_WRITE;
		b.type_index = TYPE_W'(t);
		b.coeff_slot = SLOT_W'(s);
		b.coeff_value = v;
		b.spin_x = rand_spin();
		b.spin_y = rand_spin();
		b.spin_z = rand_spin();
		b.last = 1'($urandom);
		return b;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	// Valid stays high on return so back-to-back beats leave no gap.
	task automatic send_beat(input beat_t b);
		bit full;
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.cmd = b.cmd;
		item_ch.type_index = b.type_index;
		item_ch.coeff_slot = b.coeff_slot;
		item_ch.coeff_value = b.coeff_value;
		item_ch.spin_x = b.spin_x;
		item_ch.spin_y = b.spin_y;
		item_ch.spin_z = b.spin_z;
		item_ch.last = b.last;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (b.cmd == CMD_TERM || int'(b.coeff_slot) < SLOTS)
			beats_sent++;
		// A type is only used by terms once all nine of its words hold data.
		if (b.cmd == CMD_WRITE && int'(b.coeff_slot) < SLOTS) begin
			loaded[b.type_index][b.coeff_slot] = 1'b1;
			full = 1'b1;
			for (int s = 0; s < SLOTS; s++)
				full &= loaded[b.type_index][s];
			if (full && !set_complete[b.type_index]) begin
				set_complete[b.type_index] = 1'b1;
				usable_types = {usable_types, int'(b.type_index)};
			end
		end
		@(negedge clk);
	endtask

	task automatic settle();
		item_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] m);
		settle();
		cfg_we = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_coeffs(input int t, input bit same, input coeff_t v);
		for (int s = 0; s < SLOTS; s++)
			send_beat(write_beat(t, s, same ? v : rand_coeff()));
	endtask

	// Long atom of large same-sign products that runs one bound of the sum into clipping.
	// Negative coefficients push the sum up, positive ones push it down.
	task automatic drive_to_clip(input bit upward);
		int t;
		beat_t b;
		t = $urandom_range(NUM_TYPES - 1);
		load_coeffs(t, 1'b1, upward ? COEFF_BOTTOM : COEFF_TOP);
		for (int i = 0; i < CLIP_TERMS; i++) begin
			b = term_beat(t, i == CLIP_TERMS - 1);
			b.spin_x = spin_t'($urandom_range(32767, 30000));
			b.spin_y = spin_t'($urandom_range(32767, 30000));
			b.spin_z = spin_t'($urandom_range(32767, 30000));
			send_beat(b);
		end
	endtask

	initial begin
		beat_t b;
		int    n;
		int    t;
		int    roll;
		int    phase_end;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = MODE_ISO;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_TERM;
		item_ch.type_index = '0;
		item_ch.coeff_slot = '0;
		item_ch.coeff_value = '0;
		item_ch.spin_x = '0;
		item_ch.spin_y = '0;
		item_ch.spin_z = '0;
		item_ch.last = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		beats_sent = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_mode(MODE_ISO);
		for (int s = 0; s < SLOTS; s++)
			send_beat(write_beat(0, s, EDGE_COEFFS[s]));
		load_coeffs(NUM_TYPES - 1, 1'b0, '0);
		// An atom without neighbours arrives as a single zero-spin last term.
		b = term_beat(0, 1'b1);
		b.spin_x = '0;
		b.spin_y = '0;
		b.spin_z = '0;
		send_beat(b);
		b = term_beat(0, 1'b0);
		b.spin_x = SPIN_TOP;
		b.spin_y = SPIN_BOTTOM;
		b.spin_z = '0;
		send_beat(b);
		b = term_beat(NUM_TYPES - 1, 1'b1);
		b.spin_x = SPIN_BOTTOM;
		b.spin_y = SPIN_TOP;
		b.spin_z = -16'sd1;
		send_beat(b);
		// Mode switch between two terms of the same atom.
		send_beat(term_beat(0, 1'b0));
		set_mode(MODE_VEC);
		send_beat(term_beat(NUM_TYPES - 1, 1'b1));
		// A slot past the end of the set is dropped.
		send_beat(write_beat(0, 15, COEFF_BOTTOM));
		set_mode(MODE_TENSOR);
		b = term_beat(0, 1'b1);
		b.spin_x = SPIN_TOP;
		b.spin_y = SPIN_TOP;
		b.spin_z = SPIN_TOP;
		send_beat(b);
		set_mode(MODE_UNDEF);
		b = term_beat(NUM_TYPES - 1, 1'b1);
		b.spin_x = SPIN_BOTTOM;
		b.spin_y = SPIN_BOTTOM;
		b.spin_z = SPIN_BOTTOM;
		send_beat(b);

		for (int p = 0; p < PHASES; p++) begin
			src_idle_pct = (p % 4 == 1) ? 51 : (p % 4 == 3) ? 16 : 0;
			sink_stall_pct = (p % 4 == 2) ? 51 : (p % 4 == 3) ? 16 : 0;
			set_mode(phase_mode(p));
			phase_end = beats_sent + PHASE_BEATS;
			if (p == 2 || p == 7)
				drive_to_clip(p == 7);
			while (beats_sent < phase_end) begin
				roll = $urandom_range(99);
				if (roll < 12) begin
					load_coeffs($urandom_range(NUM_TYPES - 1), $urandom_range(7) == 0,
						rand_coeff());
				end else if (roll < 22) begin
					// Lone word, now and then aimed past the end of a set.
					t = $urandom_range(1) ? usable_types[$urandom_range(usable_types.size() - 1)]
						: $urandom_range(NUM_TYPES - 1);
					send_beat(write_beat(t, $urandom_range(15), rand_coeff()));
				end else begin
					n = $urandom_range(8, 1);
					for (int i = 0; i < n; i++) begin
						if (i > 0 && $urandom_range(99) < 3)
							set_mode(MODE_W'($urandom_range(3)));
						t = usable_types[$urandom_range(usable_types.size() - 1)];
						b = term_beat(t, i == n - 1);
						if ($urandom_range(19) == 0) begin
							b.spin_x = '0;
							b.spin_y = '0;
							b.spin_z = '0;
						end
						send_beat(b);
					end
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
